FILE: hw/rtl/ect_pkg.sv
// Shared types, constants and the month table of the epoch-to-calendar converter.
// Used by every module under hw/rtl except ect_checker; depends on nothing.
package ect_pkg;

    // Seconds per day is 675 * 128: the low seven bits pass straight through.
    localparam int SecLowBits = 7;
    localparam int DayBlock = 86400 >> SecLowBits;
    localparam logic [25:0] DayRecip = 26'd50903316;   // floor(2^35 / 675)
    localparam int DayShift = 35;

    // Days counted from 1968-01-01, the leap year that opens a four-year cycle.
    localparam logic [15:0] DayBias = 16'd731;
    localparam logic [10:0] QuadDays = 11'd1461;
    localparam logic [15:0] QuadRecip = 16'd45933;     // floor(2^26 / 1461)
    localparam int QuadShift = 26;
    // First day (from 1970) of 2100-03-01; from there on a missing Feb 29 is skipped.
    localparam logic [15:0] SkipDay = 16'd47541;
    localparam logic [11:0] BaseYear = 12'd1968;

    localparam logic [11:0] HourSecs = 12'd3600;
    localparam logic [10:0] HourRecip = 11'd1165;      // floor(2^22 / 3600)
    localparam int HourShift = 22;
    localparam logic [5:0] MinSecs = 6'd60;
    localparam logic [10:0] MinRecip = 11'd1092;       // floor(2^16 / 60)
    localparam int MinShift = 16;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] sod;
    } t_split;

    // Day of year on which month idx (0 is January) begins.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        begin
            unique case (idx)
                4'd0: base = 9'd0;
                4'd1: base = 9'd31;
                4'd2: base = 9'd59;
                4'd3: base = 9'd90;
                4'd4: base = 9'd120;
                4'd5: base = 9'd151;
                4'd6: base = 9'd181;
                4'd7: base = 9'd212;
                4'd8: base = 9'd243;
                4'd9: base = 9'd273;
                4'd10: base = 9'd304;
                4'd11: base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && idx >= 4'd2) begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

FILE: hw/rtl/ect_split.sv
// Three-stage split of the second count into whole days and second of day.
// Depends on ect_pkg.
module ect_split (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [31:0]    i_secs,
    output logic           o_vld,
    output ect_pkg::t_split o_split
);

    logic [2:0]  r_vld;
    logic [24:0] r1_x;
    logic [6:0]  r1_lo;
    logic [50:0] r1_prod;
    logic [24:0] r2_x;
    logic [6:0]  r2_lo;
    logic [15:0] r2_q;
    logic [25:0] r2_qm;
    ect_pkg::t_split r3_split;

    logic [15:0] n2_q;
    logic [25:0] n2_qm;
    logic [25:0] n3_diff;
    logic [10:0] n3_rem;
    ect_pkg::t_split n3_split;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    // Quotient estimate is low by at most one; stage three corrects it.
    assign n2_q  = r1_prod[ect_pkg::DayShift +: 16];
    assign n2_qm = 26'(n2_q * 10'(ect_pkg::DayBlock));

    always_comb begin
        n3_diff = {1'b0, r2_x} - r2_qm;
        n3_rem  = n3_diff[10:0];
        n3_split.days = r2_q;
        if (n3_rem >= 11'(ect_pkg::DayBlock)) begin
            n3_rem = n3_rem - 11'(ect_pkg::DayBlock);
            n3_split.days = r2_q + 16'd1;
        end
        n3_split.sod = {n3_rem[9:0], r2_lo};
    end

    always_ff @(posedge i_clk) begin
        r1_x     <= i_secs[31:ect_pkg::SecLowBits];
        r1_lo    <= i_secs[ect_pkg::SecLowBits-1:0];
        r1_prod  <= 51'(i_secs[31:ect_pkg::SecLowBits] * ect_pkg::DayRecip);
        r2_x     <= r1_x;
        r2_lo    <= r1_lo;
        r2_q     <= n2_q;
        r2_qm    <= n2_qm;
        r3_split <= n3_split;
    end

    assign o_vld   = r_vld[2];
    assign o_split = r3_split;

endmodule

FILE: hw/rtl/ect_date.sv
// Six-stage conversion of a day count into year, month and day of month.
// Depends on ect_pkg.
module ect_date (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  ect_pkg::t_split i_split,
    output logic            o_vld,
    output logic [11:0]     o_year,
    output logic [3:0]      o_month,
    output logic [4:0]      o_day
);

    logic [5:0]  r_vld;
    logic [15:0] r4_d;
    logic [31:0] r4_prod;
    logic [15:0] r5_d;
    logic [5:0]  r5_q;
    logic [15:0] r5_qm;
    logic [5:0]  r6_quad;
    logic [10:0] r6_rem;
    logic [11:0] r7_year;
    logic [8:0]  r7_doy;
    logic        r7_leap;
    logic [11:0] r8_year;
    logic [8:0]  r8_doy;
    logic        r8_leap;
    logic [3:0]  r8_mon;
    logic [11:0] r9_year;
    logic [3:0]  r9_month;
    logic [4:0]  r9_day;

    logic [15:0] n4_d;
    logic [15:0] n6_diff;
    logic [11:0] n6_rem;
    logic [5:0]  n6_quad;
    logic [1:0]  n7_yiq;
    logic [10:0] n7_doy;
    logic [3:0]  n8_mon;
    logic [8:0]  n9_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    // From March 2100 on, one day is added so that the four-year cycle,
    // which assumes 2100 is a leap year, lands on the right date.
    assign n4_d = i_split.days + ect_pkg::DayBias
                + ((i_split.days >= ect_pkg::SkipDay) ? 16'd1 : 16'd0);

    always_comb begin
        n6_diff = r5_d - r5_qm;
        n6_rem  = n6_diff[11:0];
        n6_quad = r5_q;
        if (n6_rem >= 12'(ect_pkg::QuadDays)) begin
            n6_rem  = n6_rem - 12'(ect_pkg::QuadDays);
            n6_quad = r5_q + 6'd1;
        end
    end

    // The first year of each cycle is the leap year with 366 days.
    always_comb begin
        priority if (r6_rem < 11'd366) begin
            n7_yiq = 2'd0;
            n7_doy = r6_rem;
        end else if (r6_rem < 11'd731) begin
            n7_yiq = 2'd1;
            n7_doy = r6_rem - 11'd366;
        end else if (r6_rem < 11'd1096) begin
            n7_yiq = 2'd2;
            n7_doy = r6_rem - 11'd731;
        end else begin
            n7_yiq = 2'd3;
            n7_doy = r6_rem - 11'd1096;
        end
    end

    always_comb begin
        n8_mon = '0;
        for (int k = 1; k < 12; k++) begin
            if (r7_doy >= ect_pkg::month_start(r7_leap, 4'(k))) begin
                n8_mon = n8_mon + 4'd1;
            end
        end
    end

    assign n9_day = r8_doy - ect_pkg::month_start(r8_leap, r8_mon) + 9'd1;

    always_ff @(posedge i_clk) begin
        r4_d     <= n4_d;
        r4_prod  <= n4_d * ect_pkg::QuadRecip;
        r5_d     <= r4_d;
        r5_q     <= r4_prod[ect_pkg::QuadShift +: 6];
        r5_qm    <= 16'(r4_prod[ect_pkg::QuadShift +: 6] * ect_pkg::QuadDays);
        r6_quad  <= n6_quad;
        r6_rem   <= n6_rem[10:0];
        r7_year  <= ect_pkg::BaseYear + {4'd0, r6_quad, 2'd0} + {10'd0, n7_yiq};
        r7_doy   <= n7_doy[8:0];
        r7_leap  <= (n7_yiq == 2'd0);
        r8_year  <= r7_year;
        r8_doy   <= r7_doy;
        r8_leap  <= r7_leap;
        r8_mon   <= n8_mon;
        r9_year  <= r8_year;
        r9_month <= r8_mon + 4'd1;
        r9_day   <= n9_day[4:0];
    end

    assign o_vld   = r_vld[5];
    assign o_year  = r9_year;
    assign o_month = r9_month;
    assign o_day   = r9_day;

endmodule

FILE: hw/rtl/ect_time.sv
// Six-stage split of the second of day into hour, minute and second.
// Runs in lockstep with ect_date; depends on ect_pkg.
module ect_time (
    input  logic            i_clk,
    input  ect_pkg::t_split i_split,
    output logic [4:0]      o_hour,
    output logic [5:0]      o_minute,
    output logic [5:0]      o_second
);

    logic [16:0] r4_sod;
    logic [27:0] r4_prod;
    logic [16:0] r5_sod;
    logic [5:0]  r5_h;
    logic [16:0] r5_hm;
    logic [4:0]  r6_h;
    logic [11:0] r6_ms;
    logic [4:0]  r7_h;
    logic [11:0] r7_ms;
    logic [22:0] r7_prod;
    logic [4:0]  r8_h;
    logic [11:0] r8_ms;
    logic [5:0]  r8_m;
    logic [11:0] r8_mm;
    logic [4:0]  r9_h;
    logic [5:0]  r9_m;
    logic [5:0]  r9_s;

    logic [16:0] n6_diff;
    logic [12:0] n6_ms;
    logic [5:0]  n6_h;
    logic [11:0] n9_diff;
    logic [6:0]  n9_s;
    logic [5:0]  n9_m;

    // Both quotient estimates are low by at most one and are corrected here.
    always_comb begin
        n6_diff = r5_sod - r5_hm;
        n6_ms   = n6_diff[12:0];
        n6_h    = r5_h;
        if (n6_ms >= 13'(ect_pkg::HourSecs)) begin
            n6_ms = n6_ms - 13'(ect_pkg::HourSecs);
            n6_h  = r5_h + 6'd1;
        end
    end

    always_comb begin
        n9_diff = r8_ms - r8_mm;
        n9_s    = n9_diff[6:0];
        n9_m    = r8_m;
        if (n9_s >= 7'(ect_pkg::MinSecs)) begin
            n9_s = n9_s - 7'(ect_pkg::MinSecs);
            n9_m = r8_m + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sod  <= i_split.sod;
        r4_prod <= 28'(i_split.sod * ect_pkg::HourRecip);
        r5_sod  <= r4_sod;
        r5_h    <= r4_prod[ect_pkg::HourShift +: 6];
        r5_hm   <= 17'(r4_prod[ect_pkg::HourShift +: 6] * ect_pkg::HourSecs);
        r6_h    <= n6_h[4:0];
        r6_ms   <= n6_ms[11:0];
        r7_h    <= r6_h;
        r7_ms   <= r6_ms;
        r7_prod <= 23'(r6_ms * ect_pkg::MinRecip);
        r8_h    <= r7_h;
        r8_ms   <= r7_ms;
        r8_m    <= r7_prod[ect_pkg::MinShift +: 6];
        r8_mm   <= 12'(r7_prod[ect_pkg::MinShift +: 6] * ect_pkg::MinSecs);
        r9_h    <= r8_h;
        r9_m    <= n9_m;
        r9_s    <= n9_s[5:0];
    end

    assign o_hour   = r9_h;
    assign o_minute = r9_m;
    assign o_second = r9_s;

endmodule

FILE: hw/rtl/epoch_to_calendar_time_core.sv
// Top level of the epoch-to-calendar converter: second split, date and time pipes.
// Depends on ect_pkg, ect_split, ect_date and ect_time.
//
//   Channel   Handshake            Payload
//   input     i_start, o_busy      i_epoch_seconds
//   result    o_valid (strobe)     o_cal_year, o_cal_month, o_cal_day,
//                                  o_clock_hour, o_clock_minute, o_clock_second
//
// A transfer is taken in every cycle; o_busy stays low.
// Results come out one per input, in input order, from the pipeline:
// three stages split days from seconds, six more convert both parts in parallel.
// Latency is fixed by the pipeline depth and nothing inside ever stalls.
// Synchronous reset clears only the valid bits; items in flight are dropped.
module epoch_to_calendar_time_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    output logic [11:0] o_cal_year,
    output logic [3:0]  o_cal_month,
    output logic [4:0]  o_cal_day,
    output logic [4:0]  o_clock_hour,
    output logic [5:0]  o_clock_minute,
    output logic [5:0]  o_clock_second
);

    logic            split_vld;
    ect_pkg::t_split split;

    assign o_busy = 1'b0;

    ect_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_secs  (i_epoch_seconds),
        .o_vld   (split_vld),
        .o_split (split)
    );

    ect_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (split_vld),
        .i_split (split),
        .o_vld   (o_valid),
        .o_year  (o_cal_year),
        .o_month (o_cal_month),
        .o_day   (o_cal_day)
    );

    ect_time u_time (
        .i_clk    (i_clk),
        .i_split  (split),
        .o_hour   (o_clock_hour),
        .o_minute (o_clock_minute),
        .o_second (o_clock_second)
    );

endmodule

FILE: hw/rtl/ect_checker.sv
// Port-level checks for epoch_to_calendar_time_core, attached with a bind.
// Depends only on the top level's ports.
module ect_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [31:0] i_epoch_seconds,
    input logic        o_valid,
    input logic [11:0] o_cal_year,
    input logic [3:0]  o_cal_month,
    input logic [4:0]  o_cal_day,
    input logic [4:0]  o_clock_hour,
    input logic [5:0]  o_clock_minute,
    input logic [5:0]  o_clock_second
);

    // Counts cycles since reset so that the latency check only looks at
    // transfers made after reset was released.
    logic [3:0] r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
        end else if (r_up != 4'd10) begin
            r_up <= r_up + 4'd1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up == 4'd10) |-> (o_valid == $past(i_start && !o_busy, 9)))
        else $error("result strobe does not follow its transfer by nine cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 9))
        else $error("result without a transfer");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cal_year >= 12'd1970 && o_cal_year <= 12'd2106
                     && o_cal_month >= 4'd1 && o_cal_month <= 4'd12
                     && o_cal_day >= 5'd1))
        else $error("date out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clock_hour < 5'd24 && o_clock_minute < 6'd60
                     && o_clock_second < 6'd60))
        else $error("time of day out of range");

endmodule

bind epoch_to_calendar_time_core ect_checker u_ect_checker (.*);

FILE: sim/epoch_to_calendar_time_core_tb.sv
// Self-checking testbench for epoch_to_calendar_time_core: a queue-fed driver, a strobe monitor
// and a behavioral calendar predictor that walks years and months from 1970.
// Depends on the RTL of epoch_to_calendar_time_core only.
module epoch_to_calendar_time_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 1600;
    localparam int WatchdogLimit = 2000;
    localparam int TailCycles = 12;
    localparam longint unsigned MaxEpoch = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } civil_time_t;

    typedef struct {
        logic [31:0] secs;
        bit          drain_first;
    } epoch_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        tb_start = 1'b0;
    logic [31:0] tb_epoch = '0;
    logic        o_busy;
    logic        o_valid;
    logic [11:0] o_cal_year;
    logic [3:0]  o_cal_month;
    logic [4:0]  o_cal_day;
    logic [4:0]  o_clock_hour;
    logic [5:0]  o_clock_minute;
    logic [5:0]  o_clock_second;

    epoch_item_t epoch_items_q[$];
    civil_time_t calendar_expected[$];
    int          items_issued = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          sender_go;

    epoch_to_calendar_time_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (tb_start),
        .o_busy         (o_busy),
        .i_epoch_seconds(tb_epoch),
        .o_valid        (o_valid),
        .o_cal_year     (o_cal_year),
        .o_cal_month    (o_cal_month),
        .o_cal_day      (o_cal_day),
        .o_clock_hour   (o_clock_hour),
        .o_clock_minute (o_clock_minute),
        .o_clock_second (o_clock_second)
    );

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input bit leap, input int unsigned idx);
        int unsigned plain_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return (leap && idx == 1) ? 29 : plain_len[idx];
    endfunction

    function automatic int unsigned year_secs(input int unsigned y);
        return (leap_year(y) ? 366 : 365) * 86400;
    endfunction

    // Strip whole years, then whole months, then split the rest of the day.
    function automatic civil_time_t civil_time(input logic [31:0] secs);
        int unsigned rem;
        int unsigned year;
        int unsigned mon;
        bit          leap;
        civil_time_t ct;
        rem = secs;
        year = 1970;
        mon = 0;
        while (rem >= year_secs(year)) begin
            rem -= year_secs(year);
            year++;
        end
        leap = leap_year(year);
        while (mon < 11 && rem >= days_in_month(leap, mon) * 86400) begin
            rem -= days_in_month(leap, mon) * 86400;
            mon++;
        end
        ct.year = 12'(year);
        ct.month = 4'(mon + 1);
        ct.day = 5'(1 + rem / 86400);
        rem = rem % 86400;
        ct.hour = 5'(rem / 3600);
        rem = rem % 3600;
        ct.minute = 6'(rem / 60);
        ct.second = 6'(rem % 60);
        return ct;
    endfunction

    // Epoch of 00:00:00 on the first day of month m (1 is January) of year y.
    function automatic longint unsigned month_start_epoch(input int unsigned y,
                                                          input int unsigned m);
        longint unsigned days;
        days = 0;
        for (int unsigned yy = 1970; yy < y; yy++) begin
            days += leap_year(yy) ? 366 : 365;
        end
        for (int unsigned mm = 0; mm + 1 < m; mm++) begin
            days += days_in_month(leap_year(y), mm);
        end
        return days * 86400;
    endfunction

    task automatic queue_epoch(input longint unsigned secs, input bit drain_first);
        epoch_item_t item;
        item.secs = (secs > MaxEpoch) ? 32'($urandom) : 32'(secs);
        item.drain_first = drain_first;
        epoch_items_q.push_back(item);
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Driver: a new item goes out only once the previous one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tb_start <= 1'b0;
        end else if (!(tb_start && o_busy)) begin
            if (tb_start) begin
                calendar_expected.push_back(civil_time(tb_epoch));
                items_issued++;
            end
            sender_go = (items_issued >= 700 && items_issued < 1000) ||
                        ($urandom_range(99) >= 33);
            if (epoch_items_q.size() != 0 && epoch_items_q[0].drain_first &&
                calendar_expected.size() != 0) begin
                sender_go = 1'b0;
            end
            if (epoch_items_q.size() != 0 && sender_go) begin
                tb_start <= 1'b1;
                tb_epoch <= epoch_items_q[0].secs;
                void'(epoch_items_q.pop_front());
            end else begin
                tb_start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is one result transfer, checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (calendar_expected.size() == 0) begin
                $error("result with no expected value: %0d-%0d-%0d %0d:%0d:%0d",
                       o_cal_year, o_cal_month, o_cal_day,
                       o_clock_hour, o_clock_minute, o_clock_second);
                mismatch_count++;
            end else begin
                civil_time_t want;
                want = calendar_expected.pop_front();
                results_checked++;
                if (o_cal_year !== want.year) begin
                    $error("cal_year: expected %0d, actual %0d", want.year, o_cal_year);
                    mismatch_count++;
                end
                if (o_cal_month !== want.month) begin
                    $error("cal_month: expected %0d, actual %0d", want.month, o_cal_month);
                    mismatch_count++;
                end
                if (o_cal_day !== want.day) begin
                    $error("cal_day: expected %0d, actual %0d", want.day, o_cal_day);
                    mismatch_count++;
                end
                if (o_clock_hour !== want.hour) begin
                    $error("clock_hour: expected %0d, actual %0d", want.hour, o_clock_hour);
                    mismatch_count++;
                end
                if (o_clock_minute !== want.minute) begin
                    $error("clock_minute: expected %0d, actual %0d",
                           want.minute, o_clock_minute);
                    mismatch_count++;
                end
                if (o_clock_second !== want.second) begin
                    $error("clock_second: expected %0d, actual %0d",
                           want.second, o_clock_second);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tb_start && o_busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        longint unsigned base;
        int unsigned     pick;
        int unsigned     y;

        // Directed: range ends, year and month edges, and the century leap rules.
        queue_epoch(0, 1'b0);
        queue_epoch(MaxEpoch, 1'b0);
        queue_epoch(month_start_epoch(1971, 1) - 1, 1'b0);
        queue_epoch(month_start_epoch(1971, 1), 1'b0);
        queue_epoch(month_start_epoch(1970, 2) - 1, 1'b0);
        queue_epoch(month_start_epoch(1970, 2), 1'b0);
        queue_epoch(month_start_epoch(1970, 12), 1'b0);
        queue_epoch(month_start_epoch(1972, 3) - 86400, 1'b0);
        queue_epoch(month_start_epoch(1973, 1) - 1, 1'b0);
        queue_epoch(month_start_epoch(2000, 1), 1'b0);
        queue_epoch(month_start_epoch(2000, 3) - 86400, 1'b0);
        queue_epoch(month_start_epoch(2000, 3), 1'b0);
        queue_epoch(month_start_epoch(2100, 1), 1'b0);
        queue_epoch(month_start_epoch(2100, 3) - 1, 1'b0);
        queue_epoch(month_start_epoch(2100, 3), 1'b0);
        queue_epoch(month_start_epoch(2106, 1), 1'b0);
        queue_epoch(month_start_epoch(2106, 2) + 6 * 86400 + 23405, 1'b0);
        queue_epoch(month_start_epoch(1999, 12) + 30 * 86400 + 86399, 1'b0);
        queue_epoch(64'h7FFF_FFFF, 1'b0);
        queue_epoch(64'h8000_0000, 1'b0);
        queue_epoch(64'hAAAA_AAAA, 1'b0);
        queue_epoch(64'h5555_5555, 1'b0);

        for (int i = 0; i < RandomItems; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                base = $urandom;
            end else if (pick < 65) begin
                base = longint'($urandom_range(49710)) * 86400;
                case ($urandom_range(2))
                    0: base = base;
                    1: base = base + 86399;
                    default: base = base + $urandom_range(86399);
                endcase
            end else begin
                y = ($urandom_range(9) == 0) ? 2100 : $urandom_range(2106, 1970);
                base = month_start_epoch(y, $urandom_range(12, 1));
                case ($urandom_range(2))
                    0: base = base;
                    1: base = (base == 0) ? 0 : base - 1;
                    default: base = base + $urandom_range(59);
                endcase
            end
            queue_epoch(base, (i % 400) == 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (epoch_items_q.size() != 0 || tb_start || calendar_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TailCycles) @(posedge i_clk);

        $display("Converted %0d epoch values and checked %0d dates and times,", items_issued,
                 results_checked);
        $display("covering 1970 through 2106 with year, month, day and leap-day edges.");
        if (mismatch_count == 0 && calendar_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
